### rtl/core/first_pattern_match_splitter_macros.svh
// ----------------------------------------------------------------------------
// first pattern match splitter assertion macros
// shared property forms for the checker, clocked on i_clk, quiet in reset
// ----------------------------------------------------------------------------
`ifndef FIRST_PATTERN_MATCH_SPLITTER_MACROS_SVH
`define FIRST_PATTERN_MATCH_SPLITTER_MACROS_SVH

// same-cycle implication
`define FPMS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("fpms check failed");

// next-cycle implication
`define FPMS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("fpms check failed");

`endif

### rtl/core/fpms_pkg.sv
// ----------------------------------------------------------------------------
// fpms_pkg
// shared types and constants of the first pattern match splitter
// ----------------------------------------------------------------------------
package fpms_pkg;

    localparam int MAX_PATTERN = 8;
    localparam int WORD_W      = 32;
    localparam int CNT_W       = $clog2(MAX_PATTERN + 2);
    localparam int WIN_IDX_W   = $clog2(MAX_PATTERN);
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int LEN_W       = 4;
    localparam int PAT_REGS    = MAX_PATTERN / 2;
    localparam int Q_DEPTH     = 4;
    localparam int Q_PTR_W     = $clog2(Q_DEPTH);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_01     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_23     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_45     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_67     = 3'd4;

    typedef enum logic [1:0] {
        KIND_MATCH  = 2'd0,
        KIND_REST   = 2'd1,
        KIND_STATUS = 2'd2
    } t_kind;

    // one accepted item as a burst of results: n_rest remainder words, then
    // n_match matched words, then an optional status
    typedef struct packed {
        logic [MAX_PATTERN-1:0][WORD_W-1:0] words;
        logic [CNT_W-1:0]                   n_rest;
        logic [CNT_W-1:0]                   n_match;
        logic                               status;
        logic                               found;
    } t_job;

endpackage

### rtl/core/fpms_front.sv
// ----------------------------------------------------------------------------
// fpms_front
// config registers, pending window and per-word classification into jobs
// ----------------------------------------------------------------------------
module fpms_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [fpms_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [fpms_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_valid,
    input  logic [fpms_pkg::WORD_W-1:0]         i_word,
    input  logic                                i_end,
    output logic                                o_ready,
    input  logic                                i_q_full,
    output logic                                o_push,
    output fpms_pkg::t_job                      o_job
);

    logic [fpms_pkg::LEN_W-1:0]                             r_len;
    logic [fpms_pkg::PAT_REGS-1:0][fpms_pkg::CFG_DATA_W-1:0] r_pat;
    logic [fpms_pkg::MAX_PATTERN-1:0][fpms_pkg::WORD_W-1:0]  r_win, n_win;
    logic [fpms_pkg::CNT_W-1:0]                             r_cnt, n_cnt;
    logic                                                   r_found, n_found;

    logic [fpms_pkg::MAX_PATTERN-1:0][fpms_pkg::WORD_W-1:0]  w_pat, w_s, w_sh;
    logic [fpms_pkg::CNT_W-1:0]                             w_len, w_t, w_p0, w_k;
    logic                                                   w_eq, w_accept;

    assign o_ready  = !i_q_full;
    assign w_accept = i_valid && o_ready;

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= fpms_pkg::LEN_W'(1);
            r_pat <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                fpms_pkg::CFG_PATTERN_LENGTH: r_len    <= i_cfg_data[fpms_pkg::LEN_W-1:0];
                fpms_pkg::CFG_PATTERN_01:     r_pat[0] <= i_cfg_data;
                fpms_pkg::CFG_PATTERN_23:     r_pat[1] <= i_cfg_data;
                fpms_pkg::CFG_PATTERN_45:     r_pat[2] <= i_cfg_data;
                fpms_pkg::CFG_PATTERN_67:     r_pat[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        // clamp length to 1..max
        if (r_len == '0)
            w_len = fpms_pkg::CNT_W'(1);
        else if (fpms_pkg::CNT_W'(r_len) > fpms_pkg::CNT_W'(fpms_pkg::MAX_PATTERN))
            w_len = fpms_pkg::CNT_W'(fpms_pkg::MAX_PATTERN);
        else
            w_len = fpms_pkg::CNT_W'(r_len);

        for (int i = 0; i < fpms_pkg::MAX_PATTERN; i++)
            w_pat[i] = r_pat[i >> 1][(i & 1) * fpms_pkg::WORD_W +: fpms_pkg::WORD_W];

        // window with the new word appended
        w_s = r_win;
        w_s[r_cnt[fpms_pkg::WIN_IDX_W-1:0]] = i_word;
        w_t  = r_cnt + fpms_pkg::CNT_W'(1);
        w_p0 = (w_t > w_len) ? w_t - w_len : '0;

        // drop the words that overflow a shortened pattern
        w_k = '0;
        for (int i = 0; i < fpms_pkg::MAX_PATTERN; i++) begin
            w_k = fpms_pkg::CNT_W'(i) + w_p0;
            if (w_k >= fpms_pkg::CNT_W'(fpms_pkg::MAX_PATTERN))
                w_sh[i] = '0;
            else
                w_sh[i] = w_s[w_k[fpms_pkg::WIN_IDX_W-1:0]];
        end

        w_eq = 1'b1;
        for (int i = 0; i < fpms_pkg::MAX_PATTERN; i++)
            if (fpms_pkg::CNT_W'(i) < w_len && w_sh[i] != w_pat[i])
                w_eq = 1'b0;
    end

    always_comb begin
        n_win           = r_win;
        n_cnt           = r_cnt;
        n_found         = r_found;
        o_push          = 1'b0;
        o_job.words     = w_s;
        o_job.n_rest    = '0;
        o_job.n_match   = '0;
        o_job.status    = 1'b0;
        o_job.found     = r_found;
        if (w_accept) begin
            if (i_end) begin
                // flush pending words, then status
                o_push       = 1'b1;
                o_job.words  = r_win;
                o_job.n_rest = r_cnt;
                o_job.status = 1'b1;
                n_cnt        = '0;
                n_found      = 1'b0;
            end else if (r_found) begin
                o_push       = 1'b1;
                o_job.n_rest = fpms_pkg::CNT_W'(1);
            end else if (w_t < w_len) begin
                n_win = w_s;
                n_cnt = w_t;
            end else if (w_eq) begin
                o_push        = 1'b1;
                o_job.n_rest  = w_p0;
                o_job.n_match = w_len;
                n_cnt         = '0;
                n_found       = 1'b1;
            end else begin
                o_push       = 1'b1;
                o_job.n_rest = w_p0 + fpms_pkg::CNT_W'(1);
                for (int i = 0; i < fpms_pkg::MAX_PATTERN - 1; i++)
                    n_win[i] = w_sh[i + 1];
                n_cnt = w_len - fpms_pkg::CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_found <= 1'b0;
        end else begin
            r_cnt   <= n_cnt;
            r_found <= n_found;
        end
    end

    always_ff @(posedge i_clk) begin
        r_win <= n_win;
    end

endmodule

### rtl/core/fpms_queue.sv
// ----------------------------------------------------------------------------
// fpms_queue
// short job fifo between classifier and result sequencer
// ----------------------------------------------------------------------------
module fpms_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  fpms_pkg::t_job  i_job,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output fpms_pkg::t_job  o_job
);

    fpms_pkg::t_job                  r_mem [fpms_pkg::Q_DEPTH];
    logic [fpms_pkg::Q_PTR_W-1:0]    r_wptr, r_rptr;
    logic [fpms_pkg::Q_PTR_W:0]      r_cnt;
    logic                            w_push, w_pop;

    assign o_full  = (r_cnt == (fpms_pkg::Q_PTR_W+1)'(fpms_pkg::Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_push)
            r_mem[r_wptr] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (w_push)
                r_wptr <= r_wptr + fpms_pkg::Q_PTR_W'(1);
            if (w_pop)
                r_rptr <= r_rptr + fpms_pkg::Q_PTR_W'(1);
            if (w_push && !w_pop)
                r_cnt <= r_cnt + (fpms_pkg::Q_PTR_W+1)'(1);
            else if (w_pop && !w_push)
                r_cnt <= r_cnt - (fpms_pkg::Q_PTR_W+1)'(1);
        end
    end

endmodule

### rtl/core/fpms_back.sv
// ----------------------------------------------------------------------------
// fpms_back
// walks each job one result per cycle into the output register while the output is not stalled
// ----------------------------------------------------------------------------
module fpms_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_empty,
    input  fpms_pkg::t_job                  i_job,
    output logic                            o_pop,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [fpms_pkg::WORD_W-1:0]     o_value,
    output fpms_pkg::t_kind                 o_kind,
    output logic                            o_found,
    output logic                            o_last
);

    logic [fpms_pkg::CNT_W-1:0]     r_idx;
    logic [fpms_pkg::CNT_W-1:0]     w_total, w_match_end;
    logic                           r_valid;
    logic [fpms_pkg::WORD_W-1:0]    r_value, n_value;
    fpms_pkg::t_kind                r_kind, n_kind;
    logic                           r_found, n_found, r_last, n_last;
    logic                           w_load, w_fire;

    assign w_load      = !r_valid || i_ready;
    assign w_fire      = w_load && !i_empty;
    assign w_match_end = i_job.n_rest + i_job.n_match;
    assign w_total     = w_match_end + fpms_pkg::CNT_W'(i_job.status);
    assign o_pop       = w_fire && n_last;

    always_comb begin
        n_last  = (r_idx == w_total - fpms_pkg::CNT_W'(1));
        n_value = i_job.words[r_idx[fpms_pkg::WIN_IDX_W-1:0]];
        if (r_idx < i_job.n_rest) begin
            n_kind  = fpms_pkg::KIND_REST;
            n_found = i_job.found;
        end else if (r_idx < w_match_end) begin
            n_kind  = fpms_pkg::KIND_MATCH;
            n_found = 1'b1;
        end else begin
            n_kind  = fpms_pkg::KIND_STATUS;
            n_found = i_job.found;
            n_value = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (w_fire)
                r_idx <= n_last ? '0 : r_idx + fpms_pkg::CNT_W'(1);
            if (w_load)
                r_valid <= !i_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_value <= n_value;
            r_kind  <= n_kind;
            r_found <= n_found;
            r_last  <= n_last;
        end
    end

    assign o_valid = r_valid;
    assign o_value = r_value;
    assign o_kind  = r_kind;
    assign o_found = r_found;
    assign o_last  = r_last;

endmodule

### rtl/core/first_pattern_match_splitter.sv
// ----------------------------------------------------------------------------
// first_pattern_match_splitter
// splits a word stream at the first run that equals a configured pattern
// ----------------------------------------------------------------------------
// Takes signed 32-bit words on the slave stream, tlast marking the end of a
// sequence (its data is ignored), and returns every word in stream order on
// the master stream, tagged as matched (the first run equal to the pattern of
// 1 to 8 words) or remainder; the end word flushes pending words and adds one
// status result, and resets the search. Input is taken at one word per cycle
// while the four-entry job queue between classifier and sequencer has room.
// Output runs at one result per cycle while the receiver is ready; an input
// word yields up to 8 results (most words give 0 or 1), and a word that
// yields none puts nothing on the output. The first result of a word passes
// through the job queue and then the output register. Pattern registers are to
// be written only while the block is idle; the user must ensure this, the block does not enforce it.
module first_pattern_match_splitter (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // config write port
    input  logic                                i_cfg_we,
    input  logic [fpms_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [fpms_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // input words
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [31:0]                         i_s_axis_tdata,  // [31:0] word_value
    input  logic                                i_s_axis_tlast,  // end_of_sequence
    // result words
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    output logic [31:0]                         o_m_axis_tdata,  // [31:0] out_value
    output logic [2:0]                          o_m_axis_tuser,  // [1:0] kind, [2] match_found
    output logic                                o_m_axis_tlast   // last_of_run
);

    fpms_pkg::t_job     w_push_job, w_head_job;
    logic               w_push, w_full, w_pop, w_empty;
    fpms_pkg::t_kind    w_kind;
    logic               w_found;

    // front: window and compare, one word per cycle while the job queue has room
    fpms_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_s_axis_tvalid),
        .i_word     (i_s_axis_tdata),
        .i_end      (i_s_axis_tlast),
        .o_ready    (o_s_axis_tready),
        .i_q_full   (w_full),
        .o_push     (w_push),
        .o_job      (w_push_job)
    );

    // job queue decouples input stalls from output bursts
    fpms_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_job   (w_head_job)
    );

    // back: one result word per cycle into the output register while the receiver is ready
    fpms_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .i_job   (w_head_job),
        .o_pop   (w_pop),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_value (o_m_axis_tdata),
        .o_kind  (w_kind),
        .o_found (w_found),
        .o_last  (o_m_axis_tlast)
    );

    // tuser packs kind low, match flag above
    assign o_m_axis_tuser = {w_found, w_kind};

endmodule

### rtl/core/fpms_checker.sv
// ----------------------------------------------------------------------------
// fpms_checker
// port-level checks on the result stream of the splitter
// ----------------------------------------------------------------------------
`include "first_pattern_match_splitter_macros.svh"

module fpms_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_tvalid,
    input  logic        i_tready,
    input  logic [31:0] i_tdata,
    input  logic [2:0]  i_tuser,
    input  logic        i_tlast
);

    logic        w_status, w_match;
    logic [35:0] w_word;

    assign w_status = i_tvalid && (i_tuser[1:0] == fpms_pkg::KIND_STATUS);
    assign w_match  = i_tvalid && (i_tuser[1:0] == fpms_pkg::KIND_MATCH);
    assign w_word   = {i_tlast, i_tuser, i_tdata};

    // stalled word holds
    `FPMS_ASSERT_NEXT(a_stall_hold, i_tvalid && !i_tready, i_tvalid && $stable(w_word))
    // status always closes its run
    `FPMS_ASSERT_NOW(a_status_last, w_status, i_tlast)
    // status carries no word
    `FPMS_ASSERT_NOW(a_status_zero, w_status, i_tdata == '0)
    // matched words always report the match
    `FPMS_ASSERT_NOW(a_match_flag, w_match, i_tuser[2])

endmodule

bind first_pattern_match_splitter fpms_checker u_fpms_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_tvalid (o_m_axis_tvalid),
    .i_tready (i_m_axis_tready),
    .i_tdata  (o_m_axis_tdata),
    .i_tuser  (o_m_axis_tuser),
    .i_tlast  (o_m_axis_tlast)
);

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb: first pattern match splitter testbench
// drives word sequences with end markers against several pattern settings,
// predicts the tagged match / remainder / status words and checks each
// output word in order under random input gaps and output stalls
// ----------------------------------------------------------------------------
module tb;

    import fpms_pkg::*;

    localparam int CLK_HALF        = 10;
    localparam int RESET_CYCLES    = 9;
    localparam int SETTLE_CYCLES   = 8;     // block latency plus job queue margin
    localparam int HOLD_OFF_CYCLES = 250;
    localparam int IDLE_LIMIT      = 4000;  // cycles with no word moving on either side
    localparam int RANDOM_WORDS    = 40;
    localparam int PRINT_LIMIT     = 40;

    // register indexes past the end of the list, which the block must ignore
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_PATTERN_67 + 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = '1;

    // output stall patterns, rotated by the receiver
    localparam int RX_FREE    = 0;
    localparam int RX_COIN    = 1;
    localparam int RX_QUARTER = 2;
    localparam int RX_MOSTLY  = 3;

    typedef struct {
        t_kind             kind;
        logic [WORD_W-1:0] value;
        logic              found;
        logic              last;
    } t_result;

    // dut signals; the inputs are all known from time zero
    logic                  i_clk;
    logic                  i_rst_n         = 1'b0;
    logic                  i_cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx       = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data      = '0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [31:0]           i_s_axis_tdata  = '0;  // [31:0] word_value
    logic                  i_s_axis_tlast  = 1'b0; // end_of_sequence
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [31:0]           o_m_axis_tdata;         // [31:0] out_value
    logic [2:0]            o_m_axis_tuser;         // [1:0] kind, [2] match_found
    logic                  o_m_axis_tlast;         // last_of_run

    // predictor state: pending window, search flag and register copies
    logic [WORD_W-1:0]     win_words [MAX_PATTERN];
    int                    win_count;
    logic                  found_flag;
    logic [LEN_W-1:0]      len_reg;
    logic [CFG_DATA_W-1:0] pat_regs [PAT_REGS];
    t_result               expected_results [$];

    // bookkeeping
    int error_count;
    int words_sent;
    int results_seen;
    int matched_seen;
    int status_seen;
    int cfg_writes;
    int input_stall_cycles;
    int quiet_cycles;

    // sender and receiver pacing
    int tx_burst_left;
    bit tx_gaps_on = 1'b1;
    int rx_tick;
    int rx_hold_left;
    bit rx_hold_req;

    t_result want_result;

    first_pattern_match_splitter uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------

    // length code 0 acts as 1, codes above the window size act as a full window
    function automatic int active_length();
        int n;
        n = int'(len_reg);
        if (n == 0) n = 1;
        if (n > MAX_PATTERN) n = MAX_PATTERN;
        return n;
    endfunction

    // word 2i sits in the low half of its register, word 2i+1 in the high half
    function automatic logic [WORD_W-1:0] pattern_word(int i);
        logic [CFG_DATA_W-1:0] r;
        r = pat_regs[i / 2];
        return (i % 2) ? r[63:32] : r[31:0];
    endfunction

    function automatic logic [WORD_W-1:0] take_oldest();
        logic [WORD_W-1:0] w;
        w = win_words[0];
        for (int i = 1; i < win_count; i++) win_words[i-1] = win_words[i];
        if (win_count > 0) win_count--;
        return w;
    endfunction

    // the found flag is sampled as the word leaves, so matched words carry it
    function automatic t_result make_result(t_kind k, logic [WORD_W-1:0] v);
        t_result r;
        r.kind  = k;
        r.value = v;
        r.found = found_flag;
        r.last  = 1'b0;
        return r;
    endfunction

    // works out the output words caused by one accepted input word
    function automatic void predict_split(logic [WORD_W-1:0] word, logic eos);
        t_result burst [$];
        int      len;
        bit      equal;
        len = active_length();
        if (eos) begin
            // flush whatever is pending, then the status word
            while (win_count > 0) burst.push_back(make_result(KIND_REST, take_oldest()));
            burst.push_back(make_result(KIND_STATUS, '0));
            win_count  = 0;
            found_flag = 1'b0;
        end else if (found_flag) begin
            // search is over, words pass straight through
            burst.push_back(make_result(KIND_REST, word));
        end else begin
            if (win_count >= MAX_PATTERN)
                burst.push_back(make_result(KIND_REST, take_oldest()));
            win_words[win_count] = word;
            win_count++;
            // a length shrunk since the last word drops the oldest words first
            while (win_count > len) burst.push_back(make_result(KIND_REST, take_oldest()));
            if (win_count == len) begin
                equal = 1'b1;
                for (int i = 0; i < len; i++)
                    if (win_words[i] != pattern_word(i)) equal = 1'b0;
                if (equal) begin
                    found_flag = 1'b1;
                    for (int i = 0; i < len; i++)
                        burst.push_back(make_result(KIND_MATCH, win_words[i]));
                    win_count = 0;
                end else begin
                    burst.push_back(make_result(KIND_REST, take_oldest()));
                end
            end
        end
        if (burst.size() > 0) burst[burst.size()-1].last = 1'b1;
        foreach (burst[i]) expected_results.push_back(burst[i]);
    endfunction

    // ------------------------------------------------------------------------
    // shared drivers
    // ------------------------------------------------------------------------

    // offers one input word, with a random gap at the start of each burst
    task automatic send_word(logic [WORD_W-1:0] word, logic eos);
        int gap;
        gap = 0;
        if (tx_burst_left == 0) begin
            tx_burst_left = $urandom_range(1, 12);
            if (tx_gaps_on && $urandom_range(0, 2) != 0) gap = $urandom_range(1, 5);
        end
        tx_burst_left--;
        if (gap > 0) begin
            // junk on the data lines while valid is low
            i_s_axis_tvalid <= 1'b0;
            i_s_axis_tdata  <= $urandom;
            i_s_axis_tlast  <= 1'($urandom_range(0, 1));
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= word;
        i_s_axis_tlast  <= eos;
        do @(posedge i_clk); while (!o_s_axis_tready);
        predict_split(word, eos);
        words_sent++;
    endtask

    // drains the block; an input word may yield nothing, so allow settling time
    task automatic wait_idle();
        i_s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_PATTERN_LENGTH: len_reg = data[LEN_W-1:0];
            CFG_PATTERN_01, CFG_PATTERN_23, CFG_PATTERN_45, CFG_PATTERN_67: begin
                pat_regs[idx - CFG_PATTERN_01] = data;
            end
            default: ;
        endcase
        cfg_writes++;
        @(posedge i_clk);
    endtask

    // writes the length code (junk above it) and all four pattern registers
    task automatic load_pattern(logic [LEN_W-1:0] len_code,
                                logic [MAX_PATTERN-1:0][WORD_W-1:0] words);
        logic [CFG_DATA_W-1:0] len_data;
        len_data = {$urandom, $urandom};
        len_data[LEN_W-1:0] = len_code;
        write_reg(CFG_PATTERN_LENGTH, len_data);
        write_reg(CFG_PATTERN_01, {words[1], words[0]});
        write_reg(CFG_PATTERN_23, {words[3], words[2]});
        write_reg(CFG_PATTERN_45, {words[5], words[4]});
        write_reg(CFG_PATTERN_67, {words[7], words[6]});
    endtask

    // mostly pattern words and small values so that partial matches happen
    function automatic logic [WORD_W-1:0] random_word(int len);
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return pattern_word($urandom_range(0, len - 1));
            4:          return 32'h8000_0000;
            5:          return 32'h7fff_ffff;
            6:          return $urandom_range(0, 3);
            default:    return $urandom;
        endcase
    endfunction

    task automatic report_mismatch(string what, logic [WORD_W-1:0] got,
                                   logic [WORD_W-1:0] want);
        if (error_count < PRINT_LIMIT)
            $display("mismatch at %0t, output word %0d: %s got 0x%0h want 0x%0h",
                     $time, results_seen, what, got, want);
        error_count++;
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    task automatic test_directed();
        logic [MAX_PATTERN-1:0][WORD_W-1:0] pat;
        logic [MAX_PATTERN-1:0][WORD_W-1:0] shrunk;
        // two-word pattern at the field extremes, spare indexes poked too
        for (int i = 0; i < MAX_PATTERN; i++) pat[i] = $urandom;
        pat[0] = 32'h8000_0000;
        pat[1] = 32'h7fff_ffff;
        load_pattern(4'd2, pat);
        write_reg(CFG_SPARE_LO, {$urandom, $urandom});
        write_reg(CFG_SPARE_HI, {$urandom, $urandom});
        send_word($urandom, 1'b1);            // end marker with nothing pending
        send_word(32'h0000_0000, 1'b0);
        send_word(32'h8000_0000, 1'b0);       // overlapping start of the pattern
        send_word(32'h8000_0000, 1'b0);
        send_word(32'h7fff_ffff, 1'b0);       // match
        send_word(32'hffff_ffff, 1'b0);       // passes through after the match
        send_word($urandom, 1'b1);
        send_word(32'h8000_0000, 1'b0);       // window shorter than the pattern
        send_word($urandom, 1'b1);

        // full eight-word window, via a length code above the window size
        wait_idle();
        for (int i = 0; i < MAX_PATTERN; i++) pat[i] = $urandom;
        load_pattern(4'd15, pat);
        for (int i = 0; i < MAX_PATTERN; i++) send_word(pat[i], 1'b0);
        send_word($urandom, 1'b1);

        // seven pending words, then the length shrinks to two
        for (int i = 0; i < MAX_PATTERN - 1; i++) send_word(pat[i], 1'b0);
        wait_idle();
        shrunk    = pat;
        shrunk[0] = pat[MAX_PATTERN-2];
        shrunk[1] = $urandom;
        load_pattern(4'd2, shrunk);
        send_word(shrunk[1], 1'b0);           // six remainder words, then the match
        send_word($urandom, 1'b1);

        // length code zero acts as a single word
        wait_idle();
        pat[0] = $urandom;
        load_pattern(4'd0, pat);
        send_word(pat[0], 1'b0);
        send_word($urandom, 1'b1);
    endtask

    // receiver holds off while the sender keeps offering, so the job queue fills
    task automatic test_hold_off();
        logic [MAX_PATTERN-1:0][WORD_W-1:0] pat;
        wait_idle();
        for (int i = 0; i < MAX_PATTERN; i++) pat[i] = $urandom;
        load_pattern(4'd1, pat);
        tx_gaps_on  = 1'b0;
        rx_hold_req = 1'b1;
        send_word(pat[0], 1'b0);              // every later word is a remainder word
        repeat (30) send_word($urandom, 1'b0);
        send_word($urandom, 1'b1);
        tx_gaps_on = 1'b1;
    endtask

    // random settings, each followed by a few sequences that mostly hold the pattern
    task automatic test_random();
        logic [MAX_PATTERN-1:0][WORD_W-1:0] pat;
        logic [LEN_W-1:0] len_code;
        int target;
        int len;
        int seq_len;
        int plant_at;
        bit plant;
        target = words_sent + RANDOM_WORDS;
        while (words_sent < target) begin
            wait_idle();
            case ($urandom_range(0, 9))
                0:       len_code = 4'd0;
                1:       len_code = LEN_W'($urandom_range(MAX_PATTERN + 1, 15));
                2:       len_code = LEN_W'(MAX_PATTERN);
                3:       len_code = 4'd1;
                default: len_code = LEN_W'($urandom_range(1, MAX_PATTERN));
            endcase
            for (int i = 0; i < MAX_PATTERN; i++)
                pat[i] = ($urandom_range(0, 2) == 0) ? $urandom : $urandom_range(0, 3);
            load_pattern(len_code, pat);
            if ($urandom_range(0, 3) == 0)
                write_reg(CFG_IDX_W'($urandom_range(CFG_SPARE_LO, CFG_SPARE_HI)),
                          {$urandom, $urandom});
            len = active_length();
            tx_gaps_on = ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(1, 4)) begin
                seq_len  = $urandom_range(0, 12);
                plant    = ($urandom_range(0, 9) < 7);
                plant_at = $urandom_range(0, seq_len);
                for (int i = 0; i <= seq_len; i++) begin
                    if (plant && i == plant_at)
                        for (int j = 0; j < len; j++) send_word(pattern_word(j), 1'b0);
                    if (i < seq_len) send_word(random_word(len), 1'b0);
                end
                // now and then the sequence runs on into the next setting
                if ($urandom_range(0, 7) != 0) send_word($urandom, 1'b1);
            end
        end
        tx_gaps_on = 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // receiver: rotating stall patterns, plus a long hold-off on request
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        rx_tick++;
        if (rx_hold_req) begin
            rx_hold_left = HOLD_OFF_CYCLES;
            rx_hold_req  = 1'b0;
        end
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else if (rx_hold_left > 0) begin
            rx_hold_left--;
            i_m_axis_tready <= 1'b0;
        end else begin
            case ((rx_tick / 96) % 4)
                RX_FREE:    i_m_axis_tready <= 1'b1;
                RX_COIN:    i_m_axis_tready <= 1'($urandom_range(0, 1));
                RX_QUARTER: i_m_axis_tready <= ((rx_tick % 4) == 0);
                default:    i_m_axis_tready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // output check: each word against the oldest expectation, field by field
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                report_mismatch("word with none expected, value", o_m_axis_tdata, '0);
            end else begin
                want_result = expected_results.pop_front();
                if (o_m_axis_tuser[1:0] !== want_result.kind)
                    report_mismatch("kind", o_m_axis_tuser[1:0], want_result.kind);
                if (o_m_axis_tdata !== want_result.value)
                    report_mismatch("out_value", o_m_axis_tdata, want_result.value);
                if (o_m_axis_tuser[2] !== want_result.found)
                    report_mismatch("match_found", o_m_axis_tuser[2], want_result.found);
                if (o_m_axis_tlast !== want_result.last)
                    report_mismatch("last_of_run", o_m_axis_tlast, want_result.last);
                case (want_result.kind)
                    KIND_MATCH:  matched_seen++;
                    KIND_STATUS: status_seen++;
                    default: ;
                endcase
            end
        end
    end

    // watchdog: ends the run when no word moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready)
                     || (o_m_axis_tvalid && i_m_axis_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (i_rst_n && i_s_axis_tvalid && !o_s_axis_tready) input_stall_cycles++;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("timeout: no word accepted for %0d cycles, %0d words still expected",
                     quiet_cycles, expected_results.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        len_reg    = 4'd1;
        win_count  = 0;
        found_flag = 1'b0;
        foreach (pat_regs[i]) pat_regs[i] = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_hold_off();
        test_random();
        wait_idle();

        $display("covered %0d input words and %0d output words (%0d matched, %0d status)",
                 words_sent, results_seen, matched_seen, status_seen);
        $display("%0d register writes, input held back for %0d cycles, %0d mismatches",
                 cfg_writes, input_stall_cycles, error_count);
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
